[design/grayscale_reconstruction_by_dilation_unit_assert.svh]
// Assertion macros for the reconstruction unit
`ifndef GRAYSCALE_RECONSTRUCTION_BY_DILATION_UNIT_ASSERT_SVH
`define GRAYSCALE_RECONSTRUCTION_BY_DILATION_UNIT_ASSERT_SVH

// check that is held off while reset is asserted
`define GSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that must also hold during reset
`define GSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gsr_pkg.sv]
`timescale 1ns / 1ps

package gsr_pkg;

  localparam int ROW_BITS   = 6;
  localparam int COL_BITS   = 6;
  localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
  localparam int NPIX       = 1 << ADDR_BITS;
  localparam int DIM_BITS   = 7;
  localparam int VALUE_BITS = 16;
  localparam int QDEPTH     = 8192;
  localparam int QA_BITS    = 13;
  localparam int QC_BITS    = QA_BITS + 1;
  localparam int LEN_BITS   = ADDR_BITS + 1;
  localparam int CNT_BITS   = 13;

  localparam logic [DIM_BITS-1:0] MAX_DIM = 7'd64;
  localparam logic [VALUE_BITS-1:0] SENTINEL = 16'h8000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  // neighbour visiting order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR1,
    S_SC_VIS,
    S_SC_CHK,
    S_SC_VP,
    S_SC_NBR,
    S_SC_NBE,
    S_SC_DEC,
    S_FL_RD,
    S_FL_Q,
    S_FL_NBR,
    S_FL_NBE,
    S_SC_END,
    S_SC_NEXT,
    S_CLR2,
    S_SD_RD,
    S_SD_EV,
    S_ST_RD,
    S_ST_EV,
    S_PR_POP,
    S_PR_P,
    S_PR_VP,
    S_PR_NBR,
    S_PR_NBE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] addr;
  } nb_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] o;
    o = v;
    if (v == '0) o = 7'd1;
    else if (v > MAX_DIM) o = MAX_DIM;
    return o;
  endfunction

  // 4-neighbour of pixel p in direction k, within the used area
  function automatic nb_t nb_f(input logic [ADDR_BITS-1:0] p, input dir_t k,
                               input logic [DIM_BITS-1:0] nr,
                               input logic [DIM_BITS-1:0] nc);
    nb_t o;
    logic [ROW_BITS-1:0] r;
    logic [COL_BITS-1:0] c;
    r = p[ADDR_BITS-1:COL_BITS];
    c = p[COL_BITS-1:0];
    o.valid = 1'b0;
    o.addr  = p;
    case (k)
      DIR_UP: begin
        o.valid = (r != '0);
        o.addr  = {r - 6'd1, c};
      end
      DIR_LEFT: begin
        o.valid = (c != '0);
        o.addr  = {r, c - 6'd1};
      end
      DIR_RIGHT: begin
        o.valid = (({1'b0, c} + 7'd1) < nc);
        o.addr  = {r, c + 6'd1};
      end
      default: begin
        o.valid = (({1'b0, r} + 7'd1) < nr);
        o.addr  = {r + 6'd1, c};
      end
    endcase
    return o;
  endfunction

endpackage

[design/gsr_ram.sv]
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module gsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/grayscale_reconstruction_by_dilation_unit.sv]
`timescale 1ns / 1ps

// Grayscale reconstruction by dilation over a 64 x 64 store. Load, read and
// no-operation items are taken one per cycle while no run is in progress and
// their result strobes in the cycle after acceptance; busy stays low for them.
// A run item holds busy high for a data-dependent time set by a small
// sequencer that steps one memory access at a time: a clearing pass over all
// 4096 entries of the visited map, the raster scan for maxima (plateaus
// flooded through the plateau list), a second clearing pass, the seed marking
// and sentinel sweep, then the FIFO propagation over the neighbours of each
// queued pixel. The run result strobes as busy falls. The receiver cannot
// stall: each result is on the out_ ports for one cycle only.
module grayscale_reconstruction_by_dilation_unit
  import gsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [5:0]            in_pixel_row,
  input  logic [5:0]            in_pixel_col,
  input  logic signed [15:0]    in_marker_value,
  input  logic signed [15:0]    in_mask_value,
  output logic                  out_valid,
  output logic signed [15:0]    out_read_value,
  output logic                  out_status,
  output logic [12:0]           out_region_count,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_data
);

  state_t state_r, state_nxt;
  logic [DIM_BITS-1:0] rows_r, cols_r, nr, nc;
  logic [ROW_BITS-1:0] r_r, r_nxt;
  logic [COL_BITS-1:0] c_r, c_nxt;
  logic [ADDR_BITS-1:0] p, cur_r, cur_nxt, clr_r, clr_nxt;
  dir_t k_r, k_nxt;
  logic signed [VALUE_BITS-1:0] vp_r, vp_nxt;
  logic ismax_r, ismax_nxt, plat_r, plat_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt, n_r, n_nxt;
  logic [QA_BITS-1:0] head_r, head_nxt;
  logic [QC_BITS-1:0] qcnt_r, qcnt_nxt, seed_r, seed_nxt;
  logic [CNT_BITS-1:0] maxc_r, maxc_nxt;
  logic ovf_r, ovf_nxt;
  logic outv_r, outv_nxt, outrd_r, outrd_nxt;
  logic last_cell;
  nb_t nb;

  // memory ports
  logic mk_we, ms_we, vs_we, pl_we, qu_we;
  logic [ADDR_BITS-1:0] mk_waddr, mk_raddr, ms_waddr, ms_raddr, vs_waddr, vs_raddr;
  logic [ADDR_BITS-1:0] pl_waddr, pl_raddr, pl_wdata, pl_rdata, qu_wdata, qu_rdata;
  logic [QA_BITS-1:0] qu_waddr, qu_raddr;
  logic [VALUE_BITS-1:0] mk_wdata, mk_rdata, ms_wdata, ms_rdata;
  logic vs_wdata, vs_rdata;
  logic signed [VALUE_BITS-1:0] mm, mkv;

  gsr_ram #(.WIDTH(VALUE_BITS), .DEPTH(NPIX)) u_marker (
    .clk, .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata), .raddr(mk_raddr), .rdata(mk_rdata));
  gsr_ram #(.WIDTH(VALUE_BITS), .DEPTH(NPIX)) u_mask (
    .clk, .we(ms_we), .waddr(ms_waddr), .wdata(ms_wdata), .raddr(ms_raddr), .rdata(ms_rdata));
  gsr_ram #(.WIDTH(1), .DEPTH(NPIX)) u_visited (
    .clk, .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata), .raddr(vs_raddr), .rdata(vs_rdata));
  gsr_ram #(.WIDTH(ADDR_BITS), .DEPTH(NPIX)) u_plateau (
    .clk, .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata), .raddr(pl_raddr), .rdata(pl_rdata));
  gsr_ram #(.WIDTH(ADDR_BITS), .DEPTH(QDEPTH)) u_queue (
    .clk, .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata), .raddr(qu_raddr), .rdata(qu_rdata));

  assign nr = clamp_dim(rows_r);
  assign nc = clamp_dim(cols_r);
  assign p  = {r_r, c_r};
  assign nb = nb_f(cur_r, k_r, nr, nc);
  assign mm  = $signed(mk_rdata);
  assign mkv = $signed(ms_rdata);
  assign last_cell = (({1'b0, c_r} + 7'd1) == nc) && (({1'b0, r_r} + 7'd1) == nr);

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = outv_r;
  assign out_read_value   = outrd_r ? $signed(mk_rdata) : '0;
  assign out_status       = ovf_r;
  assign out_region_count = maxc_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= MAX_DIM;
      cols_r <= MAX_DIM;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
      outrd_r <= 1'b0;
      maxc_r  <= '0;
      ovf_r   <= 1'b0;
      head_r  <= '0;
      qcnt_r  <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      outrd_r <= outrd_nxt;
      maxc_r  <= maxc_nxt;
      ovf_r   <= ovf_nxt;
      head_r  <= head_nxt;
      qcnt_r  <= qcnt_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    cur_r   <= cur_nxt;
    clr_r   <= clr_nxt;
    k_r     <= k_nxt;
    vp_r    <= vp_nxt;
    ismax_r <= ismax_nxt;
    plat_r  <= plat_nxt;
    n_r     <= n_nxt;
    seed_r  <= seed_nxt;
  end

  // next state, memory control
  always_comb begin
    logic push;
    logic [ADDR_BITS-1:0] push_addr;
    push      = 1'b0;
    push_addr = p;

    state_nxt = state_r;
    outv_nxt  = 1'b0;
    outrd_nxt = 1'b0;
    maxc_nxt  = maxc_r;
    ovf_nxt   = ovf_r;
    head_nxt  = head_r;
    qcnt_nxt  = qcnt_r;
    len_nxt   = len_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    cur_nxt   = cur_r;
    clr_nxt   = clr_r;
    k_nxt     = k_r;
    vp_nxt    = vp_r;
    ismax_nxt = ismax_r;
    plat_nxt  = plat_r;
    n_nxt     = n_r;
    seed_nxt  = seed_r;

    mk_we = 1'b0; mk_waddr = p; mk_wdata = in_marker_value; mk_raddr = p;
    ms_we = 1'b0; ms_waddr = p; ms_wdata = in_mask_value;   ms_raddr = nb.addr;
    vs_we = 1'b0; vs_waddr = clr_r; vs_wdata = 1'b0; vs_raddr = p;
    pl_we = 1'b0; pl_waddr = len_r[ADDR_BITS-1:0]; pl_wdata = nb.addr;
    pl_raddr = n_r[ADDR_BITS-1:0];
    qu_we = 1'b0; qu_waddr = head_r + qcnt_r[QA_BITS-1:0]; qu_wdata = p;
    qu_raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        mk_raddr = {in_pixel_row, in_pixel_col};
        mk_waddr = {in_pixel_row, in_pixel_col};
        ms_waddr = {in_pixel_row, in_pixel_col};
        if (start) begin
          unique case (opcode_t'(in_opcode))
            OP_LOAD: begin
              mk_we    = 1'b1;
              ms_we    = 1'b1;
              outv_nxt = 1'b1;
            end
            OP_READ: begin
              outv_nxt  = 1'b1;
              outrd_nxt = 1'b1;
            end
            OP_RUN: begin
              clr_nxt   = '0;
              head_nxt  = '0;
              qcnt_nxt  = '0;
              maxc_nxt  = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_CLR1;
            end
            default: outv_nxt = 1'b1;
          endcase
        end
      end

      // first clearing pass of the visited map
      S_CLR1: begin
        vs_we   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_SC_VIS;
        end
      end

      // raster scan for regional maxima
      S_SC_VIS: state_nxt = S_SC_CHK;
      S_SC_CHK: begin
        if (vs_rdata) begin
          state_nxt = S_SC_NEXT;
        end else begin
          vs_we     = 1'b1;
          vs_waddr  = p;
          vs_wdata  = 1'b1;
          state_nxt = S_SC_VP;
        end
      end
      S_SC_VP: begin
        vp_nxt    = $signed(mk_rdata);
        cur_nxt   = p;
        k_nxt     = DIR_UP;
        ismax_nxt = 1'b1;
        plat_nxt  = 1'b0;
        state_nxt = S_SC_NBR;
      end
      S_SC_NBR: begin
        mk_raddr = nb.addr;
        if (nb.valid) state_nxt = S_SC_NBE;
        else if (k_r == DIR_DOWN) state_nxt = S_SC_DEC;
        else k_nxt = dir_t'(k_r + 2'd1);
      end
      S_SC_NBE: begin
        if (vp_r < mm) ismax_nxt = 1'b0;
        else if (vp_r == mm) plat_nxt = 1'b1;
        if (k_r == DIR_DOWN) begin
          state_nxt = S_SC_DEC;
        end else begin
          k_nxt     = dir_t'(k_r + 2'd1);
          state_nxt = S_SC_NBR;
        end
      end
      S_SC_DEC: begin
        if (plat_r) begin
          pl_we     = 1'b1;
          pl_waddr  = '0;
          pl_wdata  = p;
          len_nxt   = 13'd1;
          n_nxt     = '0;
          state_nxt = S_FL_RD;
        end else begin
          state_nxt = S_SC_END;
        end
      end

      // plateau flood over equal values
      S_FL_RD: begin
        if (n_r == len_r) state_nxt = S_SC_END;
        else state_nxt = S_FL_Q;
      end
      S_FL_Q: begin
        cur_nxt   = pl_rdata;
        k_nxt     = DIR_UP;
        state_nxt = S_FL_NBR;
      end
      S_FL_NBR: begin
        mk_raddr = nb.addr;
        vs_raddr = nb.addr;
        if (nb.valid) begin
          state_nxt = S_FL_NBE;
        end else if (k_r == DIR_DOWN) begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_FL_RD;
        end else begin
          k_nxt = dir_t'(k_r + 2'd1);
        end
      end
      S_FL_NBE: begin
        if (mm == vp_r) begin
          if (!vs_rdata && (len_r < NPIX[LEN_BITS-1:0])) begin
            pl_we    = 1'b1;
            vs_we    = 1'b1;
            vs_waddr = nb.addr;
            vs_wdata = 1'b1;
            len_nxt  = len_r + 1'b1;
          end
        end else if (mm > vp_r) begin
          ismax_nxt = 1'b0;
        end
        if (k_r == DIR_DOWN) begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_FL_RD;
        end else begin
          k_nxt     = dir_t'(k_r + 2'd1);
          state_nxt = S_FL_NBR;
        end
      end

      S_SC_END: begin
        if (ismax_r) begin
          if (!(&maxc_r)) maxc_nxt = maxc_r + 1'b1;
          push      = 1'b1;
          push_addr = p;
        end
        state_nxt = S_SC_NEXT;
      end
      S_SC_NEXT: begin
        if (last_cell) begin
          clr_nxt   = '0;
          state_nxt = S_CLR2;
        end else begin
          state_nxt = S_SC_VIS;
          if (({1'b0, c_r} + 7'd1) == nc) begin
            c_nxt = '0;
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end

      // second clearing pass, then mark queued seeds
      S_CLR2: begin
        vs_we   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          seed_nxt  = '0;
          state_nxt = S_SD_RD;
        end
      end
      S_SD_RD: begin
        qu_raddr = head_r + seed_r[QA_BITS-1:0];
        if (seed_r == qcnt_r) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_ST_RD;
        end else begin
          state_nxt = S_SD_EV;
        end
      end
      S_SD_EV: begin
        vs_we     = 1'b1;
        vs_waddr  = qu_rdata;
        vs_wdata  = 1'b1;
        seed_nxt  = seed_r + 1'b1;
        state_nxt = S_SD_RD;
      end

      // every unseeded pixel of the used area becomes the sentinel
      S_ST_RD: state_nxt = S_ST_EV;
      S_ST_EV: begin
        mk_wdata = SENTINEL;
        if (!vs_rdata) mk_we = 1'b1;
        if (last_cell) begin
          state_nxt = S_PR_POP;
        end else begin
          state_nxt = S_ST_RD;
          if (({1'b0, c_r} + 7'd1) == nc) begin
            c_nxt = '0;
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end

      // FIFO propagation
      S_PR_POP: begin
        if (qcnt_r == '0) begin
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          head_nxt  = head_r + 1'b1;
          qcnt_nxt  = qcnt_r - 1'b1;
          state_nxt = S_PR_P;
        end
      end
      S_PR_P: begin
        cur_nxt   = qu_rdata;
        mk_raddr  = qu_rdata;
        state_nxt = S_PR_VP;
      end
      S_PR_VP: begin
        vp_nxt    = $signed(mk_rdata);
        k_nxt     = DIR_UP;
        state_nxt = S_PR_NBR;
      end
      S_PR_NBR: begin
        mk_raddr = nb.addr;
        if (nb.valid) state_nxt = S_PR_NBE;
        else if (k_r == DIR_DOWN) state_nxt = S_PR_POP;
        else k_nxt = dir_t'(k_r + 2'd1);
      end
      S_PR_NBE: begin
        mk_waddr = nb.addr;
        mk_wdata = (vp_r < mkv) ? vp_r : mkv;
        if (!((mm >= vp_r) || (mm == mkv))) begin
          mk_we     = 1'b1;
          push      = 1'b1;
          push_addr = nb.addr;
        end
        if (k_r == DIR_DOWN) begin
          state_nxt = S_PR_POP;
        end else begin
          k_nxt     = dir_t'(k_r + 2'd1);
          state_nxt = S_PR_NBR;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // queue push, dropped with overflow when full
    qu_wdata = push_addr;
    if (push) begin
      if (qcnt_r == QDEPTH[QC_BITS-1:0]) begin
        ovf_nxt = 1'b1;
      end else begin
        qu_we    = 1'b1;
        qcnt_nxt = qcnt_nxt + 1'b1;
      end
    end
  end

`include "grayscale_reconstruction_by_dilation_unit_assert.svh"

  `GSR_ASSERT(a_qcnt_bound, (qcnt_r <= QDEPTH[QC_BITS-1:0]), "queue count beyond depth")
  `GSR_ASSERT(a_run_busy, (start && !busy && (in_opcode == OP_RUN)) |=> busy, "run not started")
  `GSR_ASSERT(a_out_idle, !(out_valid && busy), "result while busy")
  `GSR_ASSERT(a_len_bound, (len_r <= NPIX[LEN_BITS-1:0]), "plateau list overrun")

endmodule

[verif/grayscale_reconstruction_by_dilation_unit_test.sv]
`timescale 1ns / 1ps

module grayscale_reconstruction_by_dilation_unit_test;
  import gsr_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;
  localparam int ITEM_TARGET = 2000;
  localparam int UNREACHED   = -32768;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_opcode;
  logic [5:0]         in_pixel_row;
  logic [5:0]         in_pixel_col;
  logic signed [15:0] in_marker_value;
  logic signed [15:0] in_mask_value;
  logic               out_valid;
  logic signed [15:0] out_read_value;
  logic               out_status;
  logic [12:0]        out_region_count;
  logic               cfg_we;
  logic               cfg_index;
  logic [6:0]         cfg_data;

  grayscale_reconstruction_by_dilation_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_pixel_row(in_pixel_row), .in_pixel_col(in_pixel_col),
    .in_marker_value(in_marker_value), .in_mask_value(in_mask_value),
    .out_valid(out_valid), .out_read_value(out_read_value), .out_status(out_status),
    .out_region_count(out_region_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [15:0] value;
    logic               overflow;
    logic [12:0]        maxima;
  } recon_result_t;

  typedef struct {
    opcode_t     op;
    int          row;
    int          col;
    int          marker;
    int          mask;
    bit          typed;
    int          read_value;
  } pixel_cmd_t;

  // predictor state
  int  recon_marker [NPIX];
  int  recon_mask   [NPIX];
  bit  seen_map     [NPIX];
  int  plateau_buf  [NPIX];
  int  pixel_fifo   [QDEPTH];
  int  fifo_head, fifo_count;
  int  maxima_tally;
  bit  overflow_seen;
  int  rows_cfg, cols_cfg;

  // pixels loaded so far; reads only ever go to these
  bit  loaded [NPIX];
  int  loaded_list [$];

  recon_result_t pending_results [$];
  recon_result_t oldest;
  int  fail_count, cycle_count;
  int  n_loads, n_reads, n_runs, n_nops, n_items, n_ovf_runs;
  bit  burst;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_used(int v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // 4-neighbours in the order up, left, right, down
  function automatic int adj_list(int p, int nr, int nc, output int o[4]);
    int r, c, k;
    r = p / 64;
    c = p % 64;
    k = 0;
    o = '{0, 0, 0, 0};
    if (r > 0) begin o[k] = p - 64; k++; end
    if (c > 0) begin o[k] = p - 1; k++; end
    if (c + 1 < nc) begin o[k] = p + 1; k++; end
    if (r + 1 < nr) begin o[k] = p + 64; k++; end
    return k;
  endfunction

  task automatic fifo_push(int p);
    if (fifo_count >= QDEPTH) begin
      overflow_seen = 1'b1;
    end else begin
      pixel_fifo[(fifo_head + fifo_count) % QDEPTH] = p;
      fifo_count++;
    end
  endtask

  // maxima search, seeding and FIFO propagation
  task automatic reconstruct();
    int nr, nc, r, c, i, k, n, len, p, q, m;
    int nb [4];
    bit is_max, plat;
    nr = clamp_used(rows_cfg);
    nc = clamp_used(cols_cfg);
    foreach (seen_map[j]) seen_map[j] = 1'b0;
    fifo_head = 0;
    fifo_count = 0;
    maxima_tally = 0;
    overflow_seen = 1'b0;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        p = r * 64 + c;
        if (seen_map[p]) continue;
        is_max = 1'b1;
        plat = 1'b0;
        k = adj_list(p, nr, nc, nb);
        for (i = 0; i < k; i++) begin
          if (recon_marker[p] < recon_marker[nb[i]]) is_max = 1'b0;
          else if (recon_marker[p] == recon_marker[nb[i]]) plat = 1'b1;
        end
        seen_map[p] = 1'b1;
        // flood the plateau over equal values
        if (plat) begin
          plateau_buf[0] = p;
          len = 1;
          for (n = 0; n < len; n++) begin
            q = plateau_buf[n];
            k = adj_list(q, nr, nc, nb);
            for (i = 0; i < k; i++) begin
              m = nb[i];
              if (recon_marker[m] == recon_marker[q]) begin
                if (!seen_map[m] && len < NPIX) begin
                  plateau_buf[len] = m;
                  len++;
                  seen_map[m] = 1'b1;
                end
              end else if (recon_marker[m] > recon_marker[q]) begin
                is_max = 1'b0;
              end
            end
          end
        end
        if (is_max) begin
          if (maxima_tally < 8191) maxima_tally++;
          fifo_push(p);
        end
      end
    end
    // queued seeds keep their value, the rest of the used area is unreached
    foreach (seen_map[j]) seen_map[j] = 1'b0;
    for (i = 0; i < fifo_count; i++) seen_map[pixel_fifo[(fifo_head + i) % QDEPTH]] = 1'b1;
    for (r = 0; r < nr; r++)
      for (c = 0; c < nc; c++)
        if (!seen_map[r * 64 + c]) recon_marker[r * 64 + c] = UNREACHED;
    // propagation
    while (fifo_count > 0) begin
      p = pixel_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % QDEPTH;
      fifo_count--;
      k = adj_list(p, nr, nc, nb);
      for (i = 0; i < k; i++) begin
        m = nb[i];
        if (recon_marker[m] >= recon_marker[p] || recon_marker[m] == recon_mask[m]) continue;
        recon_marker[m] = (recon_marker[p] < recon_mask[m]) ? recon_marker[p] : recon_mask[m];
        fifo_push(m);
      end
    end
  endtask

  // predicted result of one accepted item
  task automatic predict_item(pixel_cmd_t cmd, output recon_result_t res);
    int p;
    p = cmd.row * 64 + cmd.col;
    res.value = '0;
    case (cmd.op)
      OP_LOAD: begin
        recon_marker[p] = cmd.marker;
        recon_mask[p] = cmd.mask;
        if (!loaded[p]) begin
          loaded[p] = 1'b1;
          loaded_list.push_back(p);
        end
        n_loads++;
      end
      OP_RUN: begin
        reconstruct();
        n_runs++;
        if (overflow_seen) n_ovf_runs++;
      end
      OP_READ: begin
        res.value = recon_marker[p][15:0];
        n_reads++;
      end
      default: n_nops++;
    endcase
    res.overflow = overflow_seen;
    res.maxima = maxima_tally[12:0];
  endtask

  // drive one item after a random gap, or none in a burst, and wait for it to be taken
  task automatic send_cmd(pixel_cmd_t cmd);
    int gap;
    recon_result_t res;
    gap = burst ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_opcode = cmd.op;
    in_pixel_row = cmd.row[5:0];
    in_pixel_col = cmd.col[5:0];
    in_marker_value = cmd.marker[15:0];
    in_mask_value = cmd.mask[15:0];
    do @(posedge clk); while (busy);
    predict_item(cmd, res);
    if (cmd.typed) res.value = cmd.read_value[15:0];
    pending_results.push_back(res);
    if (cmd.op != OP_NOP) n_items++;
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(cfg_idx_t idx, int v);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ROWS) rows_cfg = v & 127;
    else cols_cfg = v & 127;
  endtask

  function automatic pixel_cmd_t mk_cmd(opcode_t op, int row, int col, int mv, int kv);
    pixel_cmd_t cmd;
    cmd.op = op;
    cmd.row = row;
    cmd.col = col;
    cmd.marker = mv;
    cmd.mask = kv;
    cmd.typed = 1'b0;
    cmd.read_value = 0;
    return cmd;
  endfunction

  function automatic int pick_value(int spread);
    if (spread == 0) return $urandom_range(0, 65534) - 32767;
    if ($urandom_range(0, 15) == 0) return ($urandom_range(0, 1) != 0) ? 32767 : -32767;
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  task automatic random_pixel_load(int p, int spread);
    int mv, kv;
    mv = pick_value(spread);
    if ($urandom_range(0, 3) != 0) begin
      kv = mv + $urandom_range(0, (spread == 0) ? 2000 : spread);
      if (kv > 32767) kv = 32767;
    end else begin
      kv = pick_value(spread);
    end
    send_cmd(mk_cmd(OP_LOAD, p / 64, p % 64, mv, kv));
  endtask

  task automatic random_read();
    int p;
    p = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    send_cmd(mk_cmd(OP_READ, p / 64, p % 64, 0, 0));
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result value=%0d status=%0d count=%0d", $time,
                 out_read_value, out_status, out_region_count);
      end else begin
        oldest = pending_results.pop_front();
        if (out_read_value !== oldest.value) begin
          fail_count++;
          $display("%0t: read_value expected %0d got %0d", $time, oldest.value, out_read_value);
        end
        if (out_status !== oldest.overflow) begin
          fail_count++;
          $display("%0t: status expected %0d got %0d", $time, oldest.overflow, out_status);
        end
        if (out_region_count !== oldest.maxima) begin
          fail_count++;
          $display("%0t: region_count expected %0d got %0d", $time, oldest.maxima,
                   out_region_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pixel_cmd_t directed [$];
    pixel_cmd_t cmd;
    int nr, nc, spread, extra, settle;

    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_NOP;
    in_pixel_row = '0;
    in_pixel_col = '0;
    in_marker_value = '0;
    in_mask_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    burst = 1'b0;
    n_loads = 0; n_reads = 0; n_runs = 0; n_nops = 0; n_items = 0; n_ovf_runs = 0;
    rows_cfg = 64;
    cols_cfg = 64;
    foreach (recon_marker[j]) begin
      recon_marker[j] = 0;
      recon_mask[j] = 0;
      loaded[j] = 1'b0;
    end
    fifo_head = 0; fifo_count = 0; maxima_tally = 0; overflow_seen = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: 2 x 2 area, extremes, out-of-area pixel, nop, plateau
    write_reg(CFG_ROWS, 2);
    write_reg(CFG_COLS, 2);
    directed.push_back(mk_cmd(OP_LOAD, 0, 0, 32767, 32767));
    directed.push_back(mk_cmd(OP_LOAD, 0, 1, -32767, 32767));
    directed.push_back(mk_cmd(OP_LOAD, 1, 0, -1, 0));
    directed.push_back(mk_cmd(OP_LOAD, 1, 1, 0, -32767));
    directed.push_back(mk_cmd(OP_LOAD, 63, 63, 21845, -21846));
    directed.push_back(mk_cmd(OP_NOP, 63, 63, -1, -1));
    foreach (directed[j]) directed[j].typed = 1'b1;
    cmd = mk_cmd(OP_READ, 63, 63, 0, 0);
    cmd.typed = 1'b1;
    cmd.read_value = 21845;
    directed.push_back(cmd);
    cmd = mk_cmd(OP_READ, 0, 0, 0, 0);
    cmd.typed = 1'b1;
    cmd.read_value = 32767;
    directed.push_back(cmd);
    directed.push_back(mk_cmd(OP_RUN, 0, 0, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 0, 0, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 0, 1, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 1, 0, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 1, 1, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 63, 63, 0, 0));
    directed.push_back(mk_cmd(OP_LOAD, 0, 0, 5, 9));
    directed.push_back(mk_cmd(OP_LOAD, 0, 1, 5, 9));
    directed.push_back(mk_cmd(OP_LOAD, 1, 0, 5, 9));
    directed.push_back(mk_cmd(OP_LOAD, 1, 1, 2, 9));
    directed.push_back(mk_cmd(OP_RUN, 0, 0, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 1, 1, 0, 0));
    directed.push_back(mk_cmd(OP_READ, 0, 1, 0, 0));
    directed.push_back(mk_cmd(OP_NOP, 0, 0, 0, 0));
    foreach (directed[j]) send_cmd(directed[j]);

    // random phases: set the area, load all of it, mix in noise, run, read back
    while (n_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin nr = 0; nc = $urandom_range(1, 8); end
        1: begin nr = 127; nc = 1; end
        2: begin nr = $urandom_range(1, 3); nc = 127; end
        3: begin nr = $urandom_range(65, 126); nc = 0; end
        default: begin nr = $urandom_range(1, 8); nc = $urandom_range(1, 8); end
      endcase
      write_reg(CFG_ROWS, nr);
      write_reg(CFG_COLS, nc);
      burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 1;
        2: spread = 3;
        default: spread = 50;
      endcase
      for (int r = 0; r < clamp_used(nr); r++)
        for (int c = 0; c < clamp_used(nc); c++) begin
          random_pixel_load(r * 64 + c, spread);
          if ($urandom_range(0, 9) == 0) random_read();
        end
      extra = $urandom_range(0, 6);
      repeat (extra) begin
        case ($urandom_range(0, 3))
          0: random_pixel_load($urandom_range(0, NPIX - 1), spread);
          1: send_cmd(mk_cmd(OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                             pick_value(0), pick_value(0)));
          default: random_read();
        endcase
      end
      burst = ($urandom_range(0, 3) == 0);
      send_cmd(mk_cmd(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0));
      repeat ($urandom_range(4, 16)) random_read();
      // now and then a second run over the reconstructed image
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(mk_cmd(OP_RUN, 0, 0, 0, 0));
        repeat ($urandom_range(2, 6)) random_read();
      end
    end

    @(negedge clk);
    start = 1'b0;
    settle = 0;
    while (pending_results.size() != 0 && settle < 200000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);
    $display("Covered %0d items: %0d loads, %0d reads, %0d runs (%0d overflowed), %0d nops,",
             n_items + n_nops, n_loads, n_reads, n_runs, n_ovf_runs, n_nops);
    $display("with used areas from 1 pixel to full rows and columns, clamped settings too.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/gsr_pkg.sv
design/gsr_ram.sv
design/grayscale_reconstruction_by_dilation_unit.sv
verif/grayscale_reconstruction_by_dilation_unit_test.sv
